// ===== rtl/uitf_pkg.sv =====
// Shared types, constants and the digit character function of the unsigned integer text formatter.
package uitf_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONVERT,
        S_TRIM,
        S_SIZE,
        S_EMIT
    } t_phase;

    localparam logic [1:0] KIND_DEC  = 2'd0;
    localparam logic [1:0] KIND_LHEX = 2'd1;
    localparam logic [1:0] KIND_UHEX = 2'd2;

    localparam int KIND_W  = 2;
    localparam int FWID_W  = 6;
    localparam int PREC_W  = 7;
    localparam int CHAR_W  = 8;
    localparam int TOTAL_W = 6;
    localparam int LEN_W   = 7;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;

    localparam logic [TOTAL_W-1:0] OUT_MAX = 6'd63;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
        logic [CHAR_W-1:0] base;
        base = upper ? CH_UA : CH_LA;
        if (d < 4'd10) begin
            digit_char = CH_ZERO + {4'd0, d};
        end else begin
            digit_char = base + {4'd0, d} - 8'd10;
        end
    endfunction

endpackage

// ===== rtl/uitf_if.sv =====
// Request and character channel interfaces of the unsigned integer text formatter.
interface uitf_req_if #(
    parameter int VALUE_BITS = 32
);
    import uitf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [VALUE_BITS-1:0]   value;
    logic [KIND_W-1:0]       kind;
    logic [FWID_W-1:0]       field_width;
    logic signed [PREC_W-1:0] precision;
    logic                    zero_pad;
    logic                    left_justify;

    modport source (
        output valid, value, kind, field_width, precision, zero_pad, left_justify,
        input  ready
    );
    modport sink (
        input  valid, value, kind, field_width, precision, zero_pad, left_justify,
        output ready
    );
endinterface

interface uitf_chr_if;
    import uitf_pkg::*;

    logic               valid;
    logic               ready;
    logic [CHAR_W-1:0]  character;
    logic               last_char;
    logic [TOTAL_W-1:0] total_printed;

    modport source (
        output valid, character, last_char, total_printed,
        input  ready
    );
    modport sink (
        input  valid, character, last_char, total_printed,
        output ready
    );
endinterface

// ===== rtl/unsigned_int_text_formatter.sv =====
// Top level of the unsigned integer text formatter (printf %u, %x, %X style).
//
//  channel | dir | payload
//  i_req   | in  | value, kind, field_width, precision, zero_pad, left_justify
//  o_chr   | out | character, last_char, total_printed
//
// Decimal requests shift the value through a bit-serial BCD converter, one bit per
// cycle; hex requests load the nibbles directly.
// Leading zero digits are then dropped one per cycle (at most DEC_DIGITS-1 of them),
// a sizing step works out the padding, and characters leave one per cycle while the
// sink is ready, up to 63.
// A request is taken only in idle; a stalled character holds until taken.
// Reset returns the controller to idle; digit and value registers are not cleared.
module unsigned_int_text_formatter #(
    parameter int VALUE_BITS = 32,
    parameter int FIELD_MAX  = 63
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    uitf_req_if.sink     i_req,
    uitf_chr_if.source   o_chr
);
    import uitf_pkg::*;

    localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int DIG_W      = DEC_DIGITS * 4;
    localparam int CNT_W      = $clog2(DEC_DIGITS + 1);
    localparam int BIT_W      = $clog2(VALUE_BITS);
    localparam logic [LEN_W-1:0] FMAX = LEN_W'(FIELD_MAX);

    t_phase                r_state, n_state;
    logic [VALUE_BITS-1:0] r_work, n_work;
    logic [DIG_W-1:0]      r_digits, n_digits;
    logic [BIT_W-1:0]      r_bit, n_bit;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [KIND_W-1:0]     r_kind, n_kind;
    logic [LEN_W-1:0]      r_width, n_width;
    logic [LEN_W-1:0]      r_prec, n_prec;
    logic                  r_has_prec, n_has_prec;
    logic                  r_zero, n_zero;
    logic                  r_left, n_left;
    logic [LEN_W-1:0]      r_lead, n_lead;
    logic [LEN_W-1:0]      r_zeros, n_zeros;
    logic [LEN_W-1:0]      r_trail, n_trail;
    logic [TOTAL_W-1:0]    r_total, n_total;
    logic [TOTAL_W-1:0]    r_emit, n_emit;

    logic [3:0]        top;
    logic [DIG_W-1:0]  adj;
    logic [LEN_W-1:0]  in_width, in_prec;
    logic [LEN_W-1:0]  eff_cnt, zeros, core, pad, full;
    logic              last;

    assign top  = r_digits[DIG_W-1 -: 4];
    assign last = (r_emit == r_total - 6'd1);

    always_comb begin
        for (int i = 0; i < DEC_DIGITS; i++) begin
            adj[i*4 +: 4] = (r_digits[i*4 +: 4] >= 4'd5) ? r_digits[i*4 +: 4] + 4'd3
                                                         : r_digits[i*4 +: 4];
        end
    end

    always_comb begin
        in_width = {1'b0, i_req.field_width};
        if (in_width > FMAX) begin
            in_width = FMAX;
        end
        in_prec = {1'b0, i_req.precision[5:0]};
        if (i_req.precision[6]) begin
            in_prec = '0;
        end else if (in_prec > FMAX) begin
            in_prec = FMAX;
        end
    end

    always_comb begin
        eff_cnt = (r_has_prec && r_prec == '0 && top == 4'd0) ? '0 : LEN_W'(r_cnt);
        zeros   = (r_prec > eff_cnt) ? r_prec - eff_cnt : '0;
        core    = zeros + eff_cnt;
        pad     = (r_width > core) ? r_width - core : '0;
        full    = pad + core;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_emit  <= '0;
            r_total <= '0;
            r_lead  <= '0;
            r_zeros <= '0;
            r_trail <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_emit  <= n_emit;
            r_total <= n_total;
            r_lead  <= n_lead;
            r_zeros <= n_zeros;
            r_trail <= n_trail;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work     <= n_work;
        r_digits   <= n_digits;
        r_bit      <= n_bit;
        r_kind     <= n_kind;
        r_width    <= n_width;
        r_prec     <= n_prec;
        r_has_prec <= n_has_prec;
        r_zero     <= n_zero;
        r_left     <= n_left;
    end

    always_comb begin
        n_state    = r_state;
        n_work     = r_work;
        n_digits   = r_digits;
        n_bit      = r_bit;
        n_cnt      = r_cnt;
        n_kind     = r_kind;
        n_width    = r_width;
        n_prec     = r_prec;
        n_has_prec = r_has_prec;
        n_zero     = r_zero;
        n_left     = r_left;
        n_lead     = r_lead;
        n_zeros    = r_zeros;
        n_trail    = r_trail;
        n_total    = r_total;
        n_emit     = r_emit;

        i_req.ready         = 1'b0;
        o_chr.valid         = 1'b0;
        o_chr.character     = CH_SPACE;
        o_chr.last_char     = 1'b0;
        o_chr.total_printed = '0;

        unique case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_work     = i_req.value;
                    n_kind     = i_req.kind;
                    n_width    = in_width;
                    n_prec     = in_prec;
                    n_has_prec = !i_req.precision[6];
                    n_zero     = i_req.zero_pad;
                    n_left     = i_req.left_justify;
                    n_cnt      = CNT_W'(DEC_DIGITS);
                    n_bit      = BIT_W'(VALUE_BITS - 1);
                    if (i_req.kind == KIND_DEC) begin
                        n_digits = '0;
                        n_state  = S_CONVERT;
                    end else begin
                        n_digits = DIG_W'(i_req.value);
                        n_state  = S_TRIM;
                    end
                end
            end
            S_CONVERT: begin
                n_digits = {adj[DIG_W-2:0], r_work[VALUE_BITS-1]};
                n_work   = r_work << 1;
                n_bit    = r_bit - BIT_W'(1);
                if (r_bit == '0) begin
                    n_state = S_TRIM;
                end
            end
            S_TRIM: begin
                if (r_cnt > CNT_W'(1) && top == 4'd0) begin
                    n_digits = r_digits << 4;
                    n_cnt    = r_cnt - CNT_W'(1);
                end else begin
                    n_state = S_SIZE;
                end
            end
            S_SIZE: begin
                n_cnt   = eff_cnt[CNT_W-1:0];
                n_zeros = zeros;
                n_lead  = r_left ? '0 : pad;
                n_trail = r_left ? pad : '0;
                n_total = (full > LEN_W'(OUT_MAX)) ? OUT_MAX : full[TOTAL_W-1:0];
                n_emit  = '0;
                n_state = (full == '0) ? S_IDLE : S_EMIT;
            end
            S_EMIT: begin
                o_chr.valid         = 1'b1;
                o_chr.last_char     = last;
                o_chr.total_printed = last ? r_total : '0;
                priority if (r_lead != '0) begin
                    o_chr.character = (r_zero && !r_has_prec) ? CH_ZERO : CH_SPACE;
                end else if (r_zeros != '0) begin
                    o_chr.character = CH_ZERO;
                end else if (r_cnt != '0) begin
                    o_chr.character = digit_char(top, r_kind != KIND_LHEX);
                end else begin
                    o_chr.character = CH_SPACE;
                end
                if (o_chr.ready) begin
                    n_emit = r_emit + 6'd1;
                    priority if (r_lead != '0) begin
                        n_lead = r_lead - LEN_W'(1);
                    end else if (r_zeros != '0) begin
                        n_zeros = r_zeros - LEN_W'(1);
                    end else if (r_cnt != '0) begin
                        n_cnt    = r_cnt - CNT_W'(1);
                        n_digits = r_digits << 4;
                    end else begin
                        n_trail = r_trail - LEN_W'(1);
                    end
                    if (last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_last_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_chr.valid && o_chr.last_char) |-> (o_chr.total_printed == r_emit + 6'd1))
        else $error("last character count does not match characters sent");

    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_chr.valid |-> (r_emit < r_total))
        else $error("character sent beyond request length");

    a_trim_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRIM) |-> (r_cnt != '0))
        else $error("digit count empty while trimming");

    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_chr.valid && o_chr.ready && o_chr.last_char) |=> (r_state == S_IDLE))
        else $error("not idle after final character");

    a_pad_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_chr.valid && o_chr.last_char) |-> (r_emit == OUT_MAX - 6'd1 ||
            (r_lead + r_zeros + LEN_W'(r_cnt) + r_trail) == LEN_W'(1)))
        else $error("final character sent with text still pending");
`endif

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench of the unsigned integer text formatter: random and directed requests.
`timescale 1ns / 1ps

module tb;
    import uitf_pkg::*;

    localparam int    TAIL_ITEMS  = 30;
    localparam int    RAND_ITEMS  = 250;
    localparam int    DRAIN_CYCLES = 200;
    localparam real   LIMIT_NS    = 8.0 * 1200000.0;

    typedef struct {
        logic [31:0]              value;
        logic [KIND_W-1:0]        kind;
        logic [FWID_W-1:0]        fwid;
        logic signed [PREC_W-1:0] prec;
        logic                     zero_pad;
        logic                     left;
    } t_fmt_req;

    typedef struct {
        logic [CHAR_W-1:0]  ch;
        logic               last;
        logic [TOTAL_W-1:0] total;
    } t_fmt_char;

    logic i_clk = 1'b0;
    logic i_rst_n;

    uitf_req_if #(.VALUE_BITS(32)) req_if ();
    uitf_chr_if                    chr_if ();

    unsigned_int_text_formatter #(
        .VALUE_BITS (32),
        .FIELD_MAX  (63)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_chr   (chr_if)
    );

    always #4 i_clk = ~i_clk;

    t_fmt_req  fmt_req_q[$];
    t_fmt_char char_q[$];
    t_fmt_req  req_cur;
    t_fmt_char char_exp;
    int        req_gap;
    int        chr_stall;
    logic      tail_phase;
    int        n_req;
    int        n_silent;
    int        n_chr;
    int        n_err;
    int        longest;

    function automatic logic [CHAR_W-1:0] digit_glyph(input logic [3:0] d, input bit upper);
        if (d < 4'd10) begin
            return 8'h30 + {4'd0, d};
        end
        return (upper ? 8'h41 : 8'h61) + {4'd0, d} - 8'd10;
    endfunction

    function automatic void format_text(input t_fmt_req r);
        logic [3:0]        digs[20];
        logic [CHAR_W-1:0] text[$];
        logic [31:0]       v;
        int                base;
        int                ndig;
        bit                has_prec;
        int                prec;
        int                width;
        int                zeros;
        int                core;
        int                pad;
        t_fmt_char         c;
        base     = (r.kind == KIND_DEC) ? 10 : 16;
        has_prec = (r.prec >= 0);
        prec     = has_prec ? int'(r.prec) : 0;
        width    = int'(r.fwid);
        if (prec > 63) prec = 63;
        if (width > 63) width = 63;
        ndig = 0;
        v    = r.value;
        if (!(has_prec && prec == 0 && v == 0)) begin
            do begin
                digs[ndig] = 4'(v % base);
                ndig++;
                v = v / base;
            end while (v != 0);
        end
        zeros = (prec > ndig) ? prec - ndig : 0;
        core  = zeros + ndig;
        pad   = (width > core) ? width - core : 0;
        if (!r.left) begin
            repeat (pad) text.push_back((r.zero_pad && !has_prec) ? CH_ZERO : CH_SPACE);
        end
        repeat (zeros) text.push_back(CH_ZERO);
        for (int i = ndig - 1; i >= 0; i--) begin
            text.push_back(digit_glyph(digs[i], r.kind != KIND_LHEX));
        end
        if (r.left) begin
            repeat (pad) text.push_back(CH_SPACE);
        end
        if (text.size() > 63) text = text[0:62];
        if (text.size() == 0) n_silent++;
        if (text.size() > longest) longest = text.size();
        foreach (text[i]) begin
            c.ch    = text[i];
            c.last  = (i == text.size() - 1);
            c.total = c.last ? TOTAL_W'(text.size()) : '0;
            char_q.push_back(c);
        end
    endfunction

    function automatic logic [31:0] pick_value();
        int sh;
        sh = $urandom_range(0, 31);
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 9);
            1: return $urandom_range(0, 99999);
            2: return 32'd1 << sh;
            3: return (32'd1 << sh) - 32'd1;
            4: return 32'hFFFF_FFFF - $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [PREC_W-1:0] pick_prec();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return -7'sd1;
            4:          return -7'(signed'($urandom_range(1, 64)));
            5, 6, 7:    return 7'($urandom_range(0, 12));
            default:    return 7'($urandom_range(0, 63));
        endcase
    endfunction

    function automatic void add_req(input logic [31:0] value, input logic [1:0] kind,
                                    input int fwid, input int prec,
                                    input bit zero_pad, input bit left);
        t_fmt_req r;
        r.value    = value;
        r.kind     = kind;
        r.fwid     = FWID_W'(fwid);
        r.prec     = PREC_W'(prec);
        r.zero_pad = zero_pad;
        r.left     = left;
        fmt_req_q.push_back(r);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            tail_phase   <= 1'b0;
            req_gap = 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                format_text(req_cur);
                n_req++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (req_gap > 0) begin
                    req_gap--;
                    req_if.valid <= 1'b0;
                end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
                    req_gap = $urandom_range(0, 12);
                    req_if.valid <= 1'b0;
                end else if (fmt_req_q.size() != 0) begin
                    req_cur = fmt_req_q.pop_front();
                    req_if.value        <= req_cur.value;
                    req_if.kind         <= req_cur.kind;
                    req_if.field_width  <= req_cur.fwid;
                    req_if.precision    <= req_cur.prec;
                    req_if.zero_pad     <= req_cur.zero_pad;
                    req_if.left_justify <= req_cur.left;
                    req_if.valid        <= 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
            tail_phase <= (fmt_req_q.size() < TAIL_ITEMS);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            chr_if.ready <= 1'b0;
            chr_stall = 0;
        end else begin
            if (chr_if.valid && chr_if.ready) begin
                if (char_q.size() == 0) begin
                    $error("character: expected none, actual %h", chr_if.character);
                    n_err++;
                end else begin
                    char_exp = char_q.pop_front();
                    n_chr++;
                    if (chr_if.character !== char_exp.ch) begin
                        $error("character: expected %h, actual %h", char_exp.ch,
                               chr_if.character);
                        n_err++;
                    end
                    if (chr_if.last_char !== char_exp.last) begin
                        $error("last_char: expected %b, actual %b", char_exp.last,
                               chr_if.last_char);
                        n_err++;
                    end
                    if (chr_if.total_printed !== char_exp.total) begin
                        $error("total_printed: expected %0d, actual %0d", char_exp.total,
                               chr_if.total_printed);
                        n_err++;
                    end
                end
            end
            if (chr_stall > 0) begin
                chr_stall--;
                chr_if.ready <= 1'b0;
            end else if (!tail_phase && $urandom_range(0, 9) == 0) begin
                chr_stall = $urandom_range(0, 12);
                chr_if.ready <= 1'b0;
            end else begin
                chr_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        n_req    = 0;
        n_silent = 0;
        n_chr    = 0;
        n_err    = 0;
        longest  = 0;
        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.value        = '0;
        req_if.kind         = KIND_DEC;
        req_if.field_width  = '0;
        req_if.precision    = '0;
        req_if.zero_pad     = 1'b0;
        req_if.left_justify = 1'b0;
        chr_if.ready        = 1'b0;

        add_req(32'd0,          KIND_DEC,  0,  -1, 0, 0);
        add_req(32'd0,          KIND_DEC,  0,   0, 0, 0);
        add_req(32'd0,          KIND_LHEX, 5,   0, 1, 0);
        add_req(32'd0,          KIND_UHEX, 5,   0, 0, 1);
        add_req(32'hFFFF_FFFF,  KIND_DEC,  0,  -1, 0, 0);
        add_req(32'hFFFF_FFFF,  KIND_LHEX, 0,  -1, 0, 0);
        add_req(32'hFFFF_FFFF,  KIND_UHEX, 0,  -1, 0, 0);
        add_req(32'hFEDC_BA98,  2'd3,      0,   0, 0, 0);
        add_req(32'hDEAD_BEEF,  KIND_LHEX, 63, -1, 0, 1);
        add_req(32'h0ABC_DEF0,  KIND_UHEX, 20, -1, 1, 0);
        add_req(32'd12345,      KIND_DEC,  10,  8, 1, 0);
        add_req(32'd42,         KIND_DEC,  0,  63, 0, 0);
        add_req(32'd42,         KIND_DEC,  63, 63, 1, 1);
        add_req(32'd7,          KIND_DEC,  63, -1, 1, 0);
        add_req(32'd7,          KIND_DEC,  63, -1, 1, 1);
        add_req(32'd1,          KIND_DEC,  4, -64, 1, 0);
        add_req(32'd1,          KIND_LHEX, 4,  -2, 0, 0);
        add_req(32'h8000_0000,  KIND_LHEX, 0,   1, 0, 0);
        add_req(32'd9,          KIND_DEC,  0,  -1, 0, 0);
        add_req(32'd10,         KIND_DEC,  3,   1, 0, 1);
        add_req(32'd1000000000, KIND_DEC,  12,  -1, 1, 0);
        add_req(32'hFFFF_FFFF,  KIND_UHEX, 63, 63, 1, 1);
        add_req(32'd0,          KIND_DEC,  63, -1, 1, 0);
        for (int i = 0; i < RAND_ITEMS; i++) begin
            add_req(pick_value(), 2'($urandom_range(0, 3)),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 12),
                    int'(pick_prec()), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (fmt_req_q.size() != 0 || req_if.valid) @(posedge i_clk);
        while (char_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests formatted, %0d with empty text, longest %0d characters",
                 n_req, n_silent, longest);
        $display("%0d characters compared, %0d mismatches", n_chr, n_err);
        if (n_err == 0 && char_q.size() == 0) begin
            $display("unsigned_int_text_formatter test passed");
        end else begin
            $display("unsigned_int_text_formatter test failed");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("unsigned_int_text_formatter test failed");
        $finish;
    end

endmodule
